// ----- rtl/core/rcsp_pkg.sv -----
// Shared constants, codes and types for the reference-counted slot pool.
package rcsp_pkg;

   // Pool geometry.
   localparam int SLOTS      = 64;
   localparam int COUNT_BITS = 8;
   localparam int SLOT_BITS  = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   // Fixed port field widths.
   localparam int OP_W    = 2;
   localparam int IDX_W   = 6;
   localparam int STAT_W  = 2;
   localparam int RCNT_W  = 8;

   // Request operation codes.
   localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
   localparam logic [OP_W-1:0] OP_REF   = 2'd1;
   localparam logic [OP_W-1:0] OP_UNREF = 2'd2;

   // Response status codes.
   localparam logic [STAT_W-1:0] ST_OK          = 2'd0;
   localparam logic [STAT_W-1:0] ST_FULL        = 2'd1;
   localparam logic [STAT_W-1:0] ST_DOUBLE_FREE = 2'd2;
   localparam logic [STAT_W-1:0] ST_OVERFLOW    = 2'd3;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;   // latch the request and launch the count read
      logic execute;   // apply the update and load the result registers
   } ctrl_cmd_type;

endpackage

// ----- rtl/core/rcsp_ram.sv -----
// Generic simple dual-port RAM with one write port and a registered read port.
module rcsp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/rcsp_ctrl.sv -----
// Controller state machine: sequences one request through lookup and update.
module rcsp_ctrl import rcsp_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   output logic         rsp_strobe,
   output ctrl_cmd_type cmd
);

   typedef enum logic {
      ST_IDLE,
      ST_LOOKUP
   } state_type;

   state_type state_ff, state_in;
   logic      strobe_ff, strobe_in;

   // Next state and commands.
   always_comb begin
      state_in    = state_ff;
      strobe_in   = 1'b0;
      cmd.capture = 1'b0;
      cmd.execute = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               state_in    = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            cmd.execute = 1'b1;
            strobe_in   = 1'b1;
            state_in    = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State and the registered result strobe.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
      end
   end

   assign busy       = (state_ff == ST_LOOKUP);
   assign rsp_strobe = strobe_ff;

endmodule

// ----- rtl/core/rcsp_dpath.sv -----
// Datapath: busy map, first-free search, count memory and result registers.
module rcsp_dpath import rcsp_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  ctrl_cmd_type        cmd,
   input  logic [OP_W-1:0]     req_operation,
   input  logic                req_handle_present,
   input  logic [IDX_W-1:0]    req_slot_index,
   output logic [IDX_W-1:0]    rsp_slot,
   output logic [STAT_W-1:0]   rsp_status,
   output logic                rsp_released,
   output logic [RCNT_W-1:0]   rsp_new_count
);

   // One bit per slot: set when the count is nonzero. A clear bit means the
   // memory entry is stale and the count reads as zero.
   logic [SLOTS-1:0]      busy_map_ff, busy_map_in;

   // Latched request.
   logic [OP_W-1:0]       op_ff;
   logic                  have_ff;
   logic                  in_range_ff;
   logic [IDX_W-1:0]      idx_ff;
   logic [SLOT_BITS-1:0]  free_ff;
   logic                  full_ff;

   // Result registers.
   logic [IDX_W-1:0]      slot_ff, slot_in;
   logic [STAT_W-1:0]     status_ff, status_in;
   logic                  released_ff, released_in;
   logic [RCNT_W-1:0]     count_ff, count_in;

   // Search and memory signals.
   logic [SLOT_BITS-1:0]  free_idx;
   logic                  any_free;
   logic [SLOT_BITS-1:0]  addr;
   logic [COUNT_BITS-1:0] rd_data;
   logic [COUNT_BITS-1:0] cur;
   logic [COUNT_BITS-1:0] next_count;
   logic                  wr_en;
   logic [SLOT_BITS-1:0]  wr_addr;
   logic [COUNT_BITS-1:0] wr_data;

   // Lowest-numbered free slot.
   always_comb begin
      free_idx = '0;
      any_free = 1'b0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (!busy_map_ff[i]) begin
            free_idx = SLOT_BITS'(i);
            any_free = 1'b1;
         end
      end
   end

   // Capture the request at transfer.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff       <= req_operation;
         have_ff     <= req_handle_present;
         in_range_ff <= (32'(req_slot_index) < SLOTS);
         idx_ff      <= req_slot_index;
         free_ff     <= free_idx;
         full_ff     <= !any_free;
      end
   end

   // Count memory: read at transfer, written in the update cycle.
   rcsp_ram #(
      .WIDTH (COUNT_BITS),
      .DEPTH (SLOTS)
   ) u_count_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (cmd.capture),
      .rd_addr (SLOT_BITS'(req_slot_index)),
      .rd_data (rd_data)
   );

   assign addr = SLOT_BITS'(idx_ff);
   assign cur  = busy_map_ff[addr] ? rd_data : '0;

   // Update and result computation.
   always_comb begin
      busy_map_in = busy_map_ff;
      wr_en       = 1'b0;
      wr_addr     = addr;
      wr_data     = '0;
      next_count  = '0;
      slot_in     = idx_ff;
      status_in   = ST_OK;
      released_in = 1'b0;
      count_in    = '0;
      if (op_ff == OP_ALLOC) begin
         if (full_ff) begin
            slot_in   = '0;
            status_in = ST_FULL;
         end else begin
            slot_in     = IDX_W'(free_ff);
            count_in    = RCNT_W'(1);
            wr_en       = cmd.execute;
            wr_addr     = free_ff;
            wr_data     = COUNT_BITS'(1);
            busy_map_in[free_ff] = 1'b1;
         end
      end else if ((op_ff == OP_REF || op_ff == OP_UNREF) && have_ff && in_range_ff) begin
         if (op_ff == OP_REF) begin
            if (&cur) begin
               status_in = ST_OVERFLOW;
               count_in  = RCNT_W'(cur);
            end else begin
               next_count        = cur + COUNT_BITS'(1);
               count_in          = RCNT_W'(next_count);
               wr_en             = cmd.execute;
               wr_data           = next_count;
               busy_map_in[addr] = 1'b1;
            end
         end else begin
            if (cur == '0) begin
               status_in = ST_DOUBLE_FREE;
            end else begin
               next_count        = cur - COUNT_BITS'(1);
               count_in          = RCNT_W'(next_count);
               released_in       = (next_count == '0);
               wr_en             = cmd.execute;
               wr_data           = next_count;
               busy_map_in[addr] = (next_count != '0);
            end
         end
      end
   end

   // Busy map: reset marks every slot free.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_map_ff <= '0;
      end else if (cmd.execute) begin
         busy_map_ff <= busy_map_in;
      end
   end

   // Result registers load in the update cycle.
   always_ff @(posedge clock) begin
      if (cmd.execute) begin
         slot_ff     <= slot_in;
         status_ff   <= status_in;
         released_ff <= released_in;
         count_ff    <= count_in;
      end
   end

   assign rsp_slot      = slot_ff;
   assign rsp_status    = status_ff;
   assign rsp_released  = released_ff;
   assign rsp_new_count = count_ff;

endmodule

// ----- rtl/core/refcounted_slot_pool.sv -----
// Top level of the reference-counted slot pool: controller plus datapath.
//
//   Channel   Handshake            Fields
//   request   start / busy         req_operation, req_handle_present, req_slot_index
//   response  rsp_strobe (1 cyc)   rsp_slot, rsp_status, rsp_released, rsp_new_count
//
// Each request has two steps: one reads the slot's count from the count
// memory and searches the busy map, one updates the count. The response is
// shown in the cycle after the update, and a new request may be taken then,
// so requests sustain one per two cycles. Synchronous reset marks every slot
// free at once through the busy map; no clearing pass is needed. The
// receiver cannot stall the response.
module refcounted_slot_pool import rcsp_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [OP_W-1:0]   req_operation,
   input  logic              req_handle_present,
   input  logic [IDX_W-1:0]  req_slot_index,
   output logic              rsp_strobe,
   output logic [IDX_W-1:0]  rsp_slot,
   output logic [STAT_W-1:0] rsp_status,
   output logic              rsp_released,
   output logic [RCNT_W-1:0] rsp_new_count
);

   ctrl_cmd_type cmd;

   // Sequencing.
   rcsp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .cmd        (cmd)
   );

   // Storage and arithmetic.
   rcsp_dpath u_dpath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .req_operation      (req_operation),
      .req_handle_present (req_handle_present),
      .req_slot_index     (req_slot_index),
      .rsp_slot           (rsp_slot),
      .rsp_status         (rsp_status),
      .rsp_released       (rsp_released),
      .rsp_new_count      (rsp_new_count)
   );

endmodule

// ----- rtl/core/rcsp_checker.sv -----
// Port-level checker for the slot pool, bound to the top level.
module rcsp_checker import rcsp_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input logic              rsp_strobe,
   input logic [IDX_W-1:0]  rsp_slot,
   input logic [STAT_W-1:0] rsp_status,
   input logic              rsp_released,
   input logic [RCNT_W-1:0] rsp_new_count
);

   // Every accepted request yields its response after its lookup and update.
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##2 rsp_strobe)
      else $error("response missing two cycles after request transfer");

   // A response is only shown once the block is free again.
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("response shown while busy");

   // No response unless the block was busy with a request before it.
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy))
      else $error("response without a preceding request");

   // A pool-full response carries slot zero and a zero count.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_status == ST_FULL) |-> (rsp_slot == '0 && rsp_new_count == '0))
      else $error("pool-full response with nonzero fields");

   // A release always leaves the slot at zero with ok status.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_released) |-> (rsp_status == ST_OK && rsp_new_count == '0))
      else $error("release reported with nonzero count or bad status");

endmodule

bind refcounted_slot_pool rcsp_checker u_rcsp_checker (
   .clock         (clock),
   .reset         (reset),
   .start         (start),
   .busy          (busy),
   .rsp_strobe    (rsp_strobe),
   .rsp_slot      (rsp_slot),
   .rsp_status    (rsp_status),
   .rsp_released  (rsp_released),
   .rsp_new_count (rsp_new_count)
);
